// ===== src/lcs_pkg.sv =====
// Shared constants and the work-item type for the LCS length engine.
// No dependencies; imported by every module of the block.
package lcs_pkg;

  localparam int LCS_MAX_LEN     = 1024;
  localparam int LCS_SYMBOL_BITS = 8;
  localparam int SYM_W           = 8;
  localparam int LEN_W           = 11;
  localparam int CNT_FIELD_W     = 17;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ROW  = 2'd1;
  localparam logic [1:0] OP_NOP  = 2'd2;

  typedef struct packed {
    logic [1:0]             kind;
    logic [SYM_W-1:0]       sym;
    logic [CNT_FIELD_W-1:0] cnt;
    logic                   first_row;
    logic                   has_row;
    logic                   emit;
    logic                   clip;
  } op_t;

endpackage

// ===== src/lcs_length_engine.sv =====
// Top level of the LCS length engine: front end, work queue and back end.
// Depends on lcs_pkg, lcs_front, lcs_queue and lcs_back.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------------------
//   input     | push / full        | which_text, symbol, last_symbol, no_symbol
//   result    | pop / empty        | lcs_length, too_long
//
// A first-string symbol is one store write, taken straight from the queue.
// A second-string symbol sweeps the score row: one score-row memory read and write
// per stored symbol (up to MAX_LEN), then drain; no new item is taken until it ends.
// A run's result is loaded after the final row read, once the result register is free.
// Synchronous reset clears counters, phase, queue and result register; no memory pass.
// The input stalls only when the four-entry queue is full; a waiting result holds the back end.
module lcs_length_engine import lcs_pkg::*; #(
  parameter int MAX_LEN     = LCS_MAX_LEN,
  parameter int SYMBOL_BITS = LCS_SYMBOL_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             which_text,
  input  logic [SYM_W-1:0] symbol,
  input  logic             last_symbol,
  input  logic             no_symbol,
  output logic             empty,
  input  logic             pop,
  output logic [LEN_W-1:0] lcs_length,
  output logic             too_long
);

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  op_t  q_op;
  op_t  q_head;

  lcs_front #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .which_text  (which_text),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .no_symbol   (no_symbol),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_op        (q_op)
  );

  lcs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_op   (q_op),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_op   (q_head),
    .q_empty (q_empty)
  );

  lcs_back #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .lcs_length (lcs_length),
    .too_long   (too_long)
  );

endmodule

// ===== src/lcs_front.sv =====
// Front end: accepts input items, tracks string phase and counts, issues work items.
// Depends on lcs_pkg.
module lcs_front import lcs_pkg::*; #(
  parameter int MAX_LEN     = LCS_MAX_LEN,
  parameter int SYMBOL_BITS = LCS_SYMBOL_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic             which_text,
  input  logic [SYM_W-1:0] symbol,
  input  logic             last_symbol,
  input  logic             no_symbol,
  input  logic             q_full,
  output logic             q_push,
  output op_t              q_op
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

  logic [CW-1:0] fcnt, fcnt_next;
  logic [CW-1:0] scnt, scnt_next;
  logic          phase, phase_next;
  logic          clip, clip_next;
  logic          accept;
  logic          do_row;
  logic          clip_row;
  logic [SYM_W-1:0] sym;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign sym    = SYM_W'(symbol[SW-1:0]);

  always_comb begin
    fcnt_next  = fcnt;
    scnt_next  = scnt;
    phase_next = phase;
    clip_next  = clip;
    q_push     = 1'b0;
    q_op       = '0;
    do_row     = !no_symbol && (scnt < CW'(MAX_LEN));
    clip_row   = clip || (!no_symbol && !(scnt < CW'(MAX_LEN)));
    if (accept) begin
      if (!which_text && !phase) begin
        if (!no_symbol) begin
          if (fcnt < CW'(MAX_LEN)) begin
            q_push      = 1'b1;
            q_op.kind   = OP_LOAD;
            q_op.sym    = sym;
            q_op.cnt    = CNT_FIELD_W'(fcnt);
            fcnt_next   = fcnt + CW'(1);
          end else begin
            clip_next = 1'b1;
          end
        end
        if (last_symbol) begin
          phase_next = 1'b1;
          scnt_next  = '0;
        end
      end else if (which_text && phase) begin
        clip_next = clip_row;
        if (do_row) begin
          scnt_next = scnt + CW'(1);
        end
        if (do_row || last_symbol) begin
          q_push         = 1'b1;
          q_op.kind      = do_row ? OP_ROW : OP_NOP;
          q_op.sym       = sym;
          q_op.cnt       = CNT_FIELD_W'(fcnt);
          q_op.first_row = (scnt == '0);
          q_op.has_row   = (scnt != '0) || do_row;
          q_op.emit      = last_symbol;
          q_op.clip      = clip_row;
        end
        if (last_symbol) begin
          fcnt_next  = '0;
          scnt_next  = '0;
          phase_next = 1'b0;
          clip_next  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt  <= '0;
      scnt  <= '0;
      phase <= 1'b0;
      clip  <= 1'b0;
    end else begin
      fcnt  <= fcnt_next;
      scnt  <= scnt_next;
      phase <= phase_next;
      clip  <= clip_next;
    end
  end

  a_fcnt_range: assert property (@(posedge clk) disable iff (rst)
    fcnt <= CW'(MAX_LEN)) else $error("first count beyond maximum");
  a_scnt_range: assert property (@(posedge clk) disable iff (rst)
    scnt <= CW'(MAX_LEN)) else $error("second count beyond maximum");
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    accept && which_text && phase && last_symbol |=> !phase && fcnt == '0 && !clip)
    else $error("run not closed after last symbol");

endmodule

// ===== src/lcs_queue.sv =====
// Short work-item queue between front and back end.
// Depends on lcs_pkg.
module lcs_queue import lcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic q_full,
  input  logic rd_en,
  output op_t  rd_op,
  output logic q_empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  op_t             slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_op   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (PW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (PW+1)'(PW'(wr_ptr - rd_ptr)) == count || count == (PW+1)'(QUEUE_DEPTH))
    else $error("queue pointers disagree with count");
  a_wr_grows: assert property (@(posedge clk) disable iff (rst)
    do_wr && !do_rd |=> count == $past(count) + (PW+1)'(1))
    else $error("queue count did not advance");

endmodule

// ===== src/lcs_back.sv =====
// Back end: symbol store, score row memory, row sweep and result register.
// Depends on lcs_pkg.
module lcs_back import lcs_pkg::*; #(
  parameter int MAX_LEN     = LCS_MAX_LEN,
  parameter int SYMBOL_BITS = LCS_SYMBOL_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  op_t              q_head,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [LEN_W-1:0] lcs_length,
  output logic             too_long
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SW = (SYMBOL_BITS < SYM_W) ? SYMBOL_BITS : SYM_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_TAIL  = 3'd2;
  localparam logic [2:0] S_RES   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [SW-1:0] store [MAX_LEN];
  logic [CW-1:0] row   [MAX_LEN];

  logic [2:0]    state;
  op_t           op;
  logic [CW-1:0] op_cnt;
  logic [AW-1:0] j;
  logic [AW-1:0] stg_addr;
  logic          stg_valid;
  logic [SW-1:0] store_rd;
  logic [CW-1:0] row_rd;
  logic [CW-1:0] diag;
  logic [CW-1:0] left;
  logic [CW-1:0] up;
  logic [CW-1:0] dp_val;
  logic          res_zero;
  logic          out_valid;
  logic [CW-1:0] out_len;
  logic          out_clip;
  logic [AW-1:0] row_raddr;
  logic          row_ren;
  logic          j_last;
  logic [CW-1:0] head_cnt;

  assign op_cnt    = CW'(op.cnt);
  assign head_cnt  = CW'(q_head.cnt);
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign j_last    = (CW'(j) == op_cnt - CW'(1));
  assign row_ren   = (state == S_SWEEP) || (state == S_RES);
  assign row_raddr = (state == S_RES) ? AW'(op_cnt - CW'(1)) : j;
  assign up        = op.first_row ? '0 : row_rd;
  assign dp_val    = (store_rd == op.sym[SW-1:0]) ? diag + CW'(1)
                   : ((up > left) ? up : left);
  assign empty      = !out_valid;
  assign lcs_length = LEN_W'(out_len);
  assign too_long   = out_clip;

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == OP_LOAD) begin
      store[AW'(q_head.cnt)] <= q_head.sym[SW-1:0];
    end
    if (state == S_SWEEP) begin
      store_rd <= store[j];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_valid) begin
      row[stg_addr] <= dp_val;
    end
    if (row_ren) begin
      row_rd <= row[row_raddr];
    end
  end

  always_ff @(posedge clk) begin
    stg_addr <= j;
    if (q_pop) begin
      op   <= q_head;
      j    <= '0;
      diag <= '0;
      left <= '0;
    end else if (state == S_SWEEP) begin
      j <= j + AW'(1);
    end
    if (stg_valid) begin
      diag <= up;
      left <= dp_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stg_valid <= 1'b0;
      out_valid <= 1'b0;
      res_zero  <= 1'b1;
      out_len   <= '0;
      out_clip  <= 1'b0;
    end else begin
      stg_valid <= (state == S_SWEEP);
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            if (q_head.kind == OP_ROW && head_cnt != '0) begin
              state <= S_SWEEP;
            end else if (q_head.kind != OP_LOAD) begin
              state <= S_RES;
            end
          end
        end
        S_SWEEP: begin
          if (j_last) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_RES;
        end
        S_RES: begin
          res_zero <= !(op.has_row && op_cnt != '0);
          state    <= op.emit ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            out_len   <= res_zero ? '0 : row_rd;
            out_clip  <= op.clip;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sweep_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> CW'(j) < op_cnt) else $error("sweep beyond stored string");
  a_tail_to_res: assert property (@(posedge clk) disable iff (rst)
    state == S_TAIL |=> state == S_RES && !stg_valid)
    else $error("row sweep did not drain");
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !res_zero |-> row_rd <= op_cnt)
    else $error("result exceeds stored string length");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !stg_valid) else $error("work item taken during sweep");

endmodule

// ===== tb/sv/tb_lcs_length_engine.sv =====
// Testbench for lcs_length_engine: directed and random string pairs with a running
// LCS predictor, checked transfer by transfer on the result queue.
// Depends on lcs_pkg and lcs_length_engine only.
module tb_lcs_length_engine import lcs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic TEXT_A = 1'b0;
  localparam logic TEXT_B = 1'b1;
  localparam logic [SYM_W-1:0] SYM_MASK = SYM_W'((1 << LCS_SYMBOL_BITS) - 1);
  localparam int TB_AW          = $clog2(LCS_MAX_LEN);
  localparam int RX_HOLD_CYCLES = 400;
  localparam int STALL_LIMIT    = 20000;
  localparam int RANDOM_ITEMS   = 580;
  localparam int QUIET_ITEMS    = 100;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             clipped;
  } lcs_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic             which_text = TEXT_A;
  logic [SYM_W-1:0] symbol = '0;
  logic             last_symbol = 1'b0;
  logic             no_symbol = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [LEN_W-1:0] lcs_length;
  logic             too_long;

  // predictor state
  logic [SYM_W-1:0] a_syms [LCS_MAX_LEN];
  logic [LEN_W-1:0] dp_row [LCS_MAX_LEN];
  logic [LEN_W-1:0] a_count = '0;
  logic [LEN_W-1:0] b_count = '0;
  logic             b_phase = 1'b0;
  logic             row_empty = 1'b1;
  logic             clip = 1'b0;

  lcs_result_t expected_lcs_q [$];
  lcs_result_t want;
  int          errors = 0;
  int          live_items = 0;
  int          idle_cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          rx_hold_tog = 1'b0;
  bit          rx_hold_seen = 1'b0;
  int          rx_hold_cnt = 0;
  int          rx_wait = 0;

  lcs_length_engine DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .which_text  (which_text),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .no_symbol   (no_symbol),
    .empty       (empty),
    .pop         (pop),
    .lcs_length  (lcs_length),
    .too_long    (too_long)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advance the predictor by one accepted item; returns 1 when the item changes nothing
  function automatic bit predict_transfer(input logic wt, input logic [SYM_W-1:0] s,
                                          input logic lst, input logic nsym);
    logic [SYM_W-1:0] key;
    logic [LEN_W-1:0] diag, left, up, dp_val;
    lcs_result_t      res;
    int               j;
    key = s & SYM_MASK;
    if (wt == TEXT_A) begin
      if (b_phase) return 1'b1;
      if (!nsym) begin
        if (a_count < LCS_MAX_LEN) begin
          a_syms[TB_AW'(a_count)] = key;
          a_count++;
        end else begin
          clip = 1'b1;
        end
      end
      if (lst) begin
        b_phase   = 1'b1;
        row_empty = 1'b1;
        b_count   = '0;
      end
      return nsym && !lst;
    end
    if (!b_phase) return 1'b1;
    if (!nsym) begin
      if (b_count < LCS_MAX_LEN) begin
        diag = '0;
        left = '0;
        for (j = 0; j < a_count; j++) begin
          up = row_empty ? '0 : dp_row[TB_AW'(j)];
          if (a_syms[TB_AW'(j)] == key) dp_val = diag + 1'b1;
          else dp_val = (up > left) ? up : left;
          diag = up;
          left = dp_val;
          dp_row[TB_AW'(j)] = dp_val;
        end
        row_empty = 1'b0;
        b_count++;
      end else begin
        clip = 1'b1;
      end
    end
    if (!lst) return nsym;
    res.length  = (!row_empty && a_count > 0) ? dp_row[TB_AW'(a_count - 1'b1)] : '0;
    res.clipped = clip;
    expected_lcs_q.push_back(res);
    a_count   = '0;
    b_phase   = 1'b0;
    row_empty = 1'b1;
    clip      = 1'b0;
    b_count   = '0;
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int exp_val, input int got_val);
    $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, exp_val, got_val);
    errors++;
  endtask

  task automatic send_item(input logic wt, input logic [SYM_W-1:0] s,
                           input logic lst, input logic nsym);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push        <= 1'b1;
    which_text  <= wt;
    symbol      <= s;
    last_symbol <= lst;
    no_symbol   <= nsym;
    do @(posedge clk); while (full);
    if (!predict_transfer(wt, s, lst, nsym)) live_items++;
  endtask

  // send one string of n items (messy mode adds stray and no-symbol items); n == 0 sends the empty marker
  task automatic send_string(input logic wt, input int n, input logic [SYM_W-1:0] base,
                             input bit wide, input bit messy);
    logic [SYM_W-1:0] s;
    int               i;
    if (n == 0) begin
      send_item(wt, SYM_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    for (i = 0; i < n; i++) begin
      if (messy && $urandom_range(0, 15) == 0)
        send_item(!wt, SYM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      s = wide ? SYM_W'($urandom_range(0, 255)) : base ^ SYM_W'($urandom_range(0, 3));
      send_item(wt, s, i == n - 1, messy && $urandom_range(0, 19) == 0);
    end
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    do @(posedge clk); while (expected_lcs_q.size() != 0);
  endtask

  function automatic int pick_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 8);
  endfunction

  task automatic test_wrong_string_items();
    send_item(TEXT_B, 8'h41, 1'b1, 1'b0);
    send_item(TEXT_B, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_empty_strings();
    send_item(TEXT_A, 8'h00, 1'b1, 1'b1);
    send_item(TEXT_B, 8'h61, 1'b0, 1'b0);
    send_item(TEXT_B, 8'h62, 1'b1, 1'b0);
    send_item(TEXT_A, 8'h61, 1'b0, 1'b0);
    send_item(TEXT_A, 8'h62, 1'b1, 1'b0);
    send_item(TEXT_B, 8'hff, 1'b1, 1'b1);
    send_item(TEXT_A, 8'hff, 1'b1, 1'b1);
    send_item(TEXT_B, 8'h00, 1'b1, 1'b1);
  endtask

  task automatic test_symbol_extremes();
    send_item(TEXT_A, 8'h00, 1'b1, 1'b0);
    send_item(TEXT_B, 8'h00, 1'b1, 1'b0);
    send_item(TEXT_A, 8'h00, 1'b0, 1'b0);
    send_item(TEXT_A, 8'hff, 1'b0, 1'b0);
    send_item(TEXT_B, 8'hff, 1'b0, 1'b0);
    send_item(TEXT_A, 8'h0f, 1'b0, 1'b0);
    send_item(TEXT_A, 8'hf0, 1'b0, 1'b0);
    send_item(TEXT_A, 8'h55, 1'b0, 1'b0);
    send_item(TEXT_A, 8'haa, 1'b1, 1'b0);
    send_item(TEXT_B, 8'hff, 1'b0, 1'b0);
    send_item(TEXT_B, 8'h55, 1'b0, 1'b0);
    send_item(TEXT_A, 8'h55, 1'b1, 1'b0);
    send_item(TEXT_B, 8'h00, 1'b0, 1'b1);
    send_item(TEXT_B, 8'haa, 1'b0, 1'b0);
    send_item(TEXT_B, 8'hff, 1'b1, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_full_length_first();
    send_string(TEXT_A, LCS_MAX_LEN, SYM_W'($urandom_range(0, 255)), 1'b0, 1'b0);
    send_string(TEXT_B, 2, SYM_W'($urandom_range(0, 255)), 1'b1, 1'b0);
    wait_results_drained();
    send_string(TEXT_A, LCS_MAX_LEN + 2, 8'h30, 1'b0, 1'b0);
    send_string(TEXT_B, 3, 8'h30, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_full_length_second();
    send_string(TEXT_A, 3, 8'hc4, 1'b0, 1'b0);
    send_string(TEXT_B, LCS_MAX_LEN, 8'hc4, 1'b0, 1'b0);
    wait_results_drained();
    send_string(TEXT_A, 3, 8'h1b, 1'b0, 1'b0);
    send_string(TEXT_B, LCS_MAX_LEN + 3, 8'h1b, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    int k;
    tx_idle_en = 1'b0;
    rx_hold_tog <= ~rx_hold_tog;
    for (k = 0; k < 8; k++) begin
      send_string(TEXT_A, 2, 8'h7e, 1'b0, 1'b0);
      send_string(TEXT_B, 2, 8'h7e, 1'b0, 1'b0);
    end
    tx_idle_en = 1'b1;
    wait_results_drained();
  endtask

  task automatic test_random_runs();
    logic [SYM_W-1:0] base;
    bit               wide;
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      if (tx_idle_en && live_items >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
      end
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        base = SYM_W'($urandom_range(0, 255));
        wide = ($urandom_range(0, 3) == 0);
        send_string(TEXT_A, pick_len(), base, wide, 1'b1);
        send_string(TEXT_B, pick_len(), base, wide, 1'b1);
      end
    end
    wait_results_drained();
  endtask

  // result side: random stalls, plus one long hold requested by the stimulus
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (rx_hold_tog != rx_hold_seen) begin
      rx_hold_seen = rx_hold_tog;
      rx_hold_cnt  = RX_HOLD_CYCLES;
      pop <= 1'b0;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt--;
      pop <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      pop <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_wait = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_lcs_q.size() == 0) begin
        report_mismatch("unexpected result lcs_length", -1, int'(lcs_length));
      end else begin
        want = expected_lcs_q.pop_front();
        if (lcs_length !== want.length)
          report_mismatch("lcs_length", int'(want.length), int'(lcs_length));
        if (too_long !== want.clipped)
          report_mismatch("too_long", int'(want.clipped), int'(too_long));
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_lcs_length_engine failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_wrong_string_items();
    test_empty_strings();
    test_symbol_extremes();
    test_full_length_first();
    test_full_length_second();
    test_backpressure();
    test_random_runs();
    repeat (LCS_MAX_LEN + 16) @(posedge clk);
    if (errors == 0) begin
      $display("tb_lcs_length_engine passed");
    end else begin
      $display("tb_lcs_length_engine failed");
    end
    $finish;
  end

endmodule
